// ===== design/extreme_point_update_2d_assert.svh =====
// Assertion macros for the extreme point update block.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef EXTREME_POINT_UPDATE_2D_ASSERT_SVH
`define EXTREME_POINT_UPDATE_2D_ASSERT_SVH
`ifndef SYNTHESIS
`define EPU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EPU_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EPU_ASSERT(label, clk, rst_n, prop, msg)
`define EPU_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== design/epu2d_pkg.sv =====
// Shared status and configuration codes for the extreme point update block.
// No dependencies.
package epu2d_pkg;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic       CFG_LEN  = 1'b0;
    localparam logic       CFG_DEP  = 1'b1;
endpackage

// ===== design/extreme_point_update_2d.sv =====
// Top level of the extreme point update block.
// Depends on epu2d_pkg and extreme_point_update_2d_assert.svh.
//
// Usage: s_axis carries one command item {item_dep, item_len, item_y, item_x,
// mode}. Mode 1 clears the bin; mode 0 places a rectangle that the caller has
// already checked for fit. After each command the whole point list is sent on
// m_axis, one item per point, sorted by y then x, with tlast on the final
// one. An empty list gives a single item with point_valid low.
// Every step of the shared compare datapath has a read phase, which loads the
// point and rectangle stores into registers, and a compare and write-back phase.
// The work of a placement scales with its N stored rectangles and up to
// P = MAX_POINTS + 2 candidate points; a clear or an ignored item goes straight
// to the readout states S_EMITL and S_EMIT, and each output item is registered
// in S_EMIT. s_axis_tready is high only while the block is idle.
// Reset restores the list to the origin point with full bin residuals and
// empties the rectangle store. A stalled receiver simply holds the output
// register; the sequencer waits in its wait state until the item is taken.
// Configuration: i_cfg_we with i_cfg_idx 0 = bin_length, 1 = bin_depth.
`include "extreme_point_update_2d_assert.svh"
module extreme_point_update_2d
    import epu2d_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low to high: item_x, item_y, item_len, item_dep
    input  logic [63:0] s_axis_tdata,
    // tuser: mode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low to high: point_x, point_y, point_len, point_dep
    output logic [63:0] m_axis_tdata,
    // tuser, low to high: point_valid, status[1:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    localparam int CB = COORD_BITS;
    localparam int IW = $clog2(MAX_ITEMS + 1);
    localparam int IA = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int BN = MAX_POINTS + 2;
    localparam int PW = $clog2(BN + 1);
    localparam int PA = $clog2(BN);

    typedef struct packed {
        logic [CB-1:0] d;
        logic [CB-1:0] l;
        logic [CB-1:0] y;
        logic [CB-1:0] x;
    } t_rect;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CLIP  = 11'b00000000010,
        S_SCAN1 = 11'b00000000100,
        S_SCAN2 = 11'b00000001000,
        S_ZDUP  = 11'b00000010000,
        S_DOM   = 11'b00000100000,
        S_COMP  = 11'b00001000000,
        S_SORT  = 11'b00010000000,
        S_EMITL = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_WAIT  = 11'b10000000000
    } t_state;

    t_state r_state;
    logic r_ph;
    logic [CB-1:0] r_bin_len, r_bin_dep;
    t_rect  r_items [MAX_ITEMS];
    logic [IW-1:0] r_icnt;
    t_rect  r_pts [BN];
    logic [BN-1:0] r_drop;
    logic [PW-1:0] r_pcnt, r_n;
    logic [PW-1:0] r_i, r_j, r_m;
    logic [IW-1:0] r_k;
    t_rect  r_key;
    t_rect  r_pa, r_pb, r_it;
    logic [CB:0] r_top, r_right;
    logic [CB-1:0] r_bx0, r_by0, r_bx1, r_by1;
    logic [1:0] r_status;
    logic r_dup;
    logic [63:0] r_tdata;
    logic [2:0] r_tuser;
    logic r_tlast, r_tvalid;

    // Far corners carry one extra bit so that sums past the coordinate range
    // still compare correctly.
    wire [CB:0] w_kx2 = {1'b0, r_key.x} + {1'b0, r_key.l};
    wire [CB:0] w_ky2 = {1'b0, r_key.y} + {1'b0, r_key.d};
    wire [CB:0] w_ix2 = {1'b0, r_it.x} + {1'b0, r_it.l};
    wire [CB:0] w_iy2 = {1'b0, r_it.y} + {1'b0, r_it.d};
    // The sort compares neighbors j-1 and j; every other pass reads i and j.
    logic [PA-1:0] w_ra;
    assign w_ra = (r_state == S_SORT) ? PA'(r_j - 1'b1) : r_i[PA-1:0];

    function automatic logic f_less(t_rect a, t_rect b);
        if (a.y != b.y) return a.y < b.y;
        if (a.x != b.x) return a.x < b.x;
        if (a.l != b.l) return a.l < b.l;
        return a.d < b.d;
    endfunction

    function automatic logic [CB:0] f_sub(logic [CB:0] a, logic [CB:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tuser;
    assign m_axis_tlast  = r_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_len <= CB'(16'hFFFF);
            r_bin_dep <= CB'(16'hFFFF);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEN: r_bin_len <= CB'(i_cfg_data);
                CFG_DEP: r_bin_dep <= CB'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Registered reads of both stores and the rectangle store write.
    always_ff @(posedge i_clk) begin
        r_pa <= r_pts[w_ra];
        r_pb <= r_pts[r_j[PA-1:0]];
        r_it <= r_items[r_k[IA-1:0]];
        if (r_state == S_EMITL && r_dup) begin
            r_items[r_icnt[IA-1:0]] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= 1'b0;
            r_icnt   <= '0;
            r_pcnt   <= PW'(1);
            r_pts[0] <= '{d: CB'(16'hFFFF), l: CB'(16'hFFFF), y: '0, x: '0};
            r_tvalid <= 1'b0;
            r_dup    <= 1'b0;
        end else if (r_state != S_IDLE && r_state != S_EMITL && r_state != S_WAIT
                     && !r_ph) begin
            // Read cycle: the stores are sampled at the current indexes.
            r_ph <= 1'b1;
        end else begin
            r_ph <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_dup <= 1'b0;
                    if (s_axis_tvalid) begin
                        r_key  <= '{d: CB'(s_axis_tdata[63:48]), l: CB'(s_axis_tdata[47:32]),
                                   y: CB'(s_axis_tdata[31:16]), x: CB'(s_axis_tdata[15:0])};
                        r_status <= ST_OK;
                        r_i <= '0; r_m <= '0; r_k <= '0;
                        r_top <= '0; r_right <= '0;
                        if (s_axis_tuser) begin
                            r_icnt   <= '0;
                            r_pts[0] <= '{d: r_bin_dep, l: r_bin_len, y: '0, x: '0};
                            r_pcnt   <= PW'(1);
                            r_state  <= S_EMITL;
                        end else if (r_icnt >= IW'(MAX_ITEMS)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_EMITL;
                        end else begin
                            r_state <= S_CLIP;
                        end
                    end
                end
                // Remove covered points and clip residuals, compacting in place.
                S_CLIP: begin
                    if (r_i >= r_pcnt) begin
                        r_n <= r_m;
                        r_state <= S_SCAN1;
                    end else begin
                        if (!(r_key.x <= r_pa.x && r_pa.x < w_kx2 &&
                              r_key.y <= r_pa.y && r_pa.y < w_ky2)) begin
                            t_rect p;
                            p = r_pa;
                            if (p.x <= r_key.x && p.y >= r_key.y && p.y < w_ky2 &&
                                r_key.x - p.x < p.l)
                                p.l = r_key.x - p.x;
                            if (p.y <= r_key.y && p.x >= r_key.x && p.x < w_kx2 &&
                                r_key.y - p.y < p.d)
                                p.d = r_key.y - p.y;
                            r_pts[r_m[PA-1:0]] <= p;
                            r_m <= r_m + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                // Projections of the new corners onto the stored items.
                S_SCAN1: begin
                    if (r_k >= r_icnt) begin
                        r_k <= '0;
                        r_bx0 <= r_bin_len; r_by0 <= r_bin_dep;
                        r_bx1 <= r_bin_len; r_by1 <= r_bin_dep;
                        r_state <= S_SCAN2;
                    end else begin
                        if (w_iy2 <= r_key.y && r_it.x <= w_kx2 && w_kx2 < w_ix2 &&
                            w_iy2 > r_top) r_top <= w_iy2;
                        if (w_ix2 <= r_key.x && r_it.y <= w_ky2 && w_ky2 < w_iy2 &&
                            w_ix2 > r_right) r_right <= w_ix2;
                        r_k <= r_k + 1'b1;
                    end
                end
                // Residual bounds for both new points. A corner past the
                // coordinate range ends with a zero residual and is dropped.
                S_SCAN2: begin
                    if (r_k >= r_icnt) begin
                        r_pts[r_n[PA-1:0]] <= '{d: CB'(f_sub({1'b0, r_by0}, r_top)),
                            l: CB'(f_sub({1'b0, r_bx0}, w_kx2)),
                            y: r_top[CB-1:0], x: w_kx2[CB-1:0]};
                        r_pts[PA'(r_n + 1'b1)] <= '{d: CB'(f_sub({1'b0, r_by1}, w_ky2)),
                            l: CB'(f_sub({1'b0, r_bx1}, r_right)),
                            y: w_ky2[CB-1:0], x: r_right[CB-1:0]};
                        r_n <= r_n + PW'(2);
                        r_i <= '0; r_j <= '0; r_m <= '0;
                        r_state <= S_ZDUP;
                    end else begin
                        if (r_top <= r_it.y && r_it.x <= w_kx2 && w_kx2 < w_ix2 &&
                            r_it.y < r_by0) r_by0 <= r_it.y;
                        if (w_kx2 <= r_it.x && r_it.y <= r_top && r_top < w_iy2 &&
                            r_it.x < r_bx0) r_bx0 <= r_it.x;
                        if (w_ky2 <= r_it.y && r_it.x <= r_right && r_right < w_ix2 &&
                            r_it.y < r_by1) r_by1 <= r_it.y;
                        if (r_right <= r_it.x && r_it.y <= w_ky2 && w_ky2 < w_iy2 &&
                            r_it.x < r_bx1) r_bx1 <= r_it.x;
                        r_k <= r_k + 1'b1;
                    end
                end
                // Drop zero residuals and duplicates: j walks the kept prefix.
                S_ZDUP: begin
                    if (r_i >= r_n) begin
                        r_n <= r_m;
                        r_drop <= '0;
                        r_i <= '0; r_j <= '0;
                        r_state <= S_DOM;
                    end else if (r_pa.l == '0 || r_pa.d == '0) begin
                        r_i <= r_i + 1'b1; r_j <= '0;
                    end else if (r_j < r_m) begin
                        if (r_pb == r_pa) begin
                            r_i <= r_i + 1'b1; r_j <= '0;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        r_pts[r_m[PA-1:0]] <= r_pa;
                        r_m <= r_m + 1'b1;
                        r_i <= r_i + 1'b1; r_j <= '0;
                    end
                end
                // All-pairs dominance, one pair per step.
                S_DOM: begin
                    if (r_i >= r_n) begin
                        r_i <= '0; r_m <= '0;
                        r_state <= S_COMP;
                    end else begin
                        if (r_i != r_j && r_pa.x <= r_pb.x && r_pa.y <= r_pb.y &&
                            r_pa.l >= r_pb.l && r_pa.d >= r_pb.d)
                            r_drop[r_j[PA-1:0]] <= 1'b1;
                        if (r_j + 1'b1 >= r_n) begin
                            r_j <= '0; r_i <= r_i + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_COMP: begin
                    if (r_i >= r_n) begin
                        r_n <= r_m;
                        r_i <= PW'(1); r_j <= PW'(1);
                        r_state <= S_SORT;
                    end else begin
                        if (!r_drop[r_i[PA-1:0]]) begin
                            r_pts[r_m[PA-1:0]] <= r_pa;
                            r_m <= r_m + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                // Insertion sort by adjacent swaps; r_j walks down from r_i.
                S_SORT: begin
                    if (r_i >= r_n) begin
                        if (r_n > PW'(MAX_POINTS)) begin
                            r_pcnt <= PW'(MAX_POINTS);
                            r_status <= ST_TRUNC;
                        end else begin
                            r_pcnt <= r_n;
                        end
                        r_dup <= 1'b1;
                        r_state <= S_EMITL;
                    end else if (r_j != '0 && f_less(r_pb, r_pa)) begin
                        r_pts[r_j[PA-1:0]] <= r_pa;
                        r_pts[PA'(r_j - 1'b1)] <= r_pb;
                        r_j <= r_j - 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + 1'b1;
                    end
                end
                // Store the rectangle after a placement and set up the list readout.
                S_EMITL: begin
                    if (r_dup) r_icnt <= r_icnt + 1'b1;
                    r_i <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_tvalid <= 1'b1;
                    if (r_pcnt == '0) begin
                        r_tdata <= '0;
                        r_tuser <= {r_status, 1'b0};
                        r_tlast <= 1'b1;
                    end else begin
                        r_tdata <= {16'(r_pa.d), 16'(r_pa.l), 16'(r_pa.y), 16'(r_pa.x)};
                        r_tuser <= {r_status, 1'b1};
                        r_tlast <= (r_i + 1'b1 >= r_pcnt);
                    end
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (m_axis_tready) begin
                        r_tvalid <= 1'b0;
                        if (r_tlast) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_EMIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `EPU_ASSERT(a_ready_idle, i_clk, i_rst_n, s_axis_tready |-> !m_axis_tvalid, "busy while idle")
    `EPU_ASSERT(a_pcnt_cap, i_clk, i_rst_n, r_pcnt <= PW'(MAX_POINTS), "point count over capacity")
    `EPU_ASSERT(a_icnt_cap, i_clk, i_rst_n, r_icnt <= IW'(MAX_ITEMS), "item count over capacity")
    `EPU_ASSERT_RST(a_reset, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
endmodule

// ===== tb/extreme_point_update_2d_check.sv =====
// Checker for extreme_point_update_2d: predicts each point list from the commands it sees.
// It then compares the lists with the block's output items.
// Depends on epu2d_pkg for status and register codes.
`timescale 1ns / 1ps

module extreme_point_update_2d_check
    import epu2d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int NITEMS = 64;
    localparam int NPTS   = 32;

    typedef struct packed {
        bit [31:0] x;
        bit [31:0] y;
        bit [31:0] l;
        bit [31:0] d;
    } rect_t;

    typedef struct {
        bit [15:0] x, y, l, d;
        bit        valid;
        bit        last;
        bit [1:0]  status;
    } point_item_t;

    bit [31:0]   bin_len, bin_dep;
    rect_t       placed[NITEMS];
    int          n_placed;
    rect_t       pts[NPTS];
    int          n_pts;
    point_item_t want_points[$];

    function automatic bit [31:0] min32(bit [31:0] a, bit [31:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic bit [31:0] sub_sat(bit [31:0] a, bit [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    function automatic bit sorts_first(rect_t a, rect_t b);
        if (a.y != b.y) return a.y < b.y;
        if (a.x != b.x) return a.x < b.x;
        if (a.l != b.l) return a.l < b.l;
        return a.d < b.d;
    endfunction

    function automatic void restart_points();
        pts[0] = '{x: 0, y: 0, l: bin_len, d: bin_dep};
        n_pts  = 1;
    endfunction

    // Free run from a new point up to the bin edge or the nearest stored item.
    function automatic rect_t with_residual(rect_t p);
        bit [31:0] bx, by;
        bx = bin_len;
        by = bin_dep;
        for (int i = 0; i < n_placed; i++) begin
            if (p.y <= placed[i].y && placed[i].x <= p.x && p.x < placed[i].x + placed[i].l)
                by = min32(by, placed[i].y);
            if (p.x <= placed[i].x && placed[i].y <= p.y && p.y < placed[i].y + placed[i].d)
                bx = min32(bx, placed[i].x);
        end
        p.l = sub_sat(bx, p.x);
        p.d = sub_sat(by, p.y);
        return p;
    endfunction

    // Places one rectangle and rebuilds the point list; returns 1 on truncation.
    function automatic bit place_rect(rect_t k);
        rect_t     buf_pts[NPTS + 2];
        bit        drop[NPTS + 2];
        rect_t     p, t;
        bit [31:0] kx2, ky2, top, right, ix2, iy2;
        int        n, m, j;
        bit        dup;
        n = 0;
        kx2 = k.x + k.l;
        ky2 = k.y + k.d;
        top = 0;
        right = 0;
        for (int i = 0; i < n_pts; i++) begin
            p = pts[i];
            if (!(k.x <= p.x && p.x < kx2 && k.y <= p.y && p.y < ky2)) begin
                if (p.x <= k.x && p.y >= k.y && p.y < ky2) p.l = min32(p.l, k.x - p.x);
                if (p.y <= k.y && p.x >= k.x && p.x < kx2) p.d = min32(p.d, k.y - p.y);
                buf_pts[n++] = p;
            end
        end
        for (int i = 0; i < n_placed; i++) begin
            ix2 = placed[i].x + placed[i].l;
            iy2 = placed[i].y + placed[i].d;
            if (iy2 <= k.y && placed[i].x <= kx2 && kx2 < ix2 && iy2 > top) top = iy2;
            if (ix2 <= k.x && placed[i].y <= ky2 && ky2 < iy2 && ix2 > right) right = ix2;
        end
        buf_pts[n++] = with_residual('{x: kx2, y: top, l: 0, d: 0});
        buf_pts[n++] = with_residual('{x: right, y: ky2, l: 0, d: 0});

        // Zero-residual points and exact duplicates go first.
        m = 0;
        for (int i = 0; i < n; i++) begin
            if (buf_pts[i].l != 0 && buf_pts[i].d != 0) begin
                dup = 0;
                for (int q = 0; q < m; q++) if (buf_pts[q] == buf_pts[i]) dup = 1;
                if (!dup) buf_pts[m++] = buf_pts[i];
            end
        end
        n = m;

        // A point is dominated when another sits lower-left with at least its residuals.
        for (int i = 0; i < n; i++) drop[i] = 0;
        for (int i = 0; i < n; i++)
            for (int q = 0; q < n; q++)
                if (i != q && buf_pts[i].x <= buf_pts[q].x && buf_pts[i].y <= buf_pts[q].y &&
                    buf_pts[i].l >= buf_pts[q].l && buf_pts[i].d >= buf_pts[q].d)
                    drop[q] = 1;
        m = 0;
        for (int i = 0; i < n; i++) if (!drop[i]) buf_pts[m++] = buf_pts[i];
        n = m;

        for (int i = 1; i < n; i++) begin
            t = buf_pts[i];
            j = i;
            while (j > 0 && sorts_first(t, buf_pts[j - 1])) begin
                buf_pts[j] = buf_pts[j - 1];
                j--;
            end
            buf_pts[j] = t;
        end

        place_rect = (n > NPTS);
        if (n > NPTS) n = NPTS;
        for (int i = 0; i < n; i++) pts[i] = buf_pts[i];
        n_pts = n;
        placed[n_placed] = k;
        n_placed++;
    endfunction

    function automatic void run_command(bit mode, bit [63:0] data);
        bit [1:0]    status;
        point_item_t e;
        rect_t       k;
        status = ST_OK;
        if (mode) begin
            n_placed = 0;
            restart_points();
        end else if (n_placed >= NITEMS) begin
            status = ST_FULL;
        end else begin
            k = '{x: data[15:0], y: data[31:16], l: data[47:32], d: data[63:48]};
            if (place_rect(k)) status = ST_TRUNC;
        end
        if (n_pts == 0) begin
            e = '{x: 0, y: 0, l: 0, d: 0, valid: 0, last: 1, status: status};
            want_points.push_back(e);
        end
        for (int i = 0; i < n_pts; i++) begin
            e.x = pts[i].x[15:0];
            e.y = pts[i].y[15:0];
            e.l = pts[i].l[15:0];
            e.d = pts[i].d[15:0];
            e.valid = 1;
            e.last = (i + 1 == n_pts);
            e.status = status;
            want_points.push_back(e);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s is %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        point_item_t e;
        if (!i_rst_n) begin
            bin_len = 16'hFFFF;
            bin_dep = 16'hFFFF;
            n_placed = 0;
            restart_points();
            want_points.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LEN) bin_len = i_cfg_data;
                else bin_dep = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) run_command(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (want_points.size() == 0) begin
                    report_mismatch("pending point lists", 0, 1);
                end else begin
                    e = want_points.pop_front();
                    if (m_axis_tdata[15:0] != e.x) report_mismatch("point_x", m_axis_tdata[15:0], e.x);
                    if (m_axis_tdata[31:16] != e.y) report_mismatch("point_y", m_axis_tdata[31:16], e.y);
                    if (m_axis_tdata[47:32] != e.l)
                        report_mismatch("point_len", m_axis_tdata[47:32], e.l);
                    if (m_axis_tdata[63:48] != e.d)
                        report_mismatch("point_dep", m_axis_tdata[63:48], e.d);
                    if (m_axis_tuser[0] != e.valid)
                        report_mismatch("point_valid", m_axis_tuser[0], e.valid);
                    if (m_axis_tuser[2:1] != e.status)
                        report_mismatch("status", m_axis_tuser[2:1], e.status);
                    if (m_axis_tlast != e.last) report_mismatch("last", m_axis_tlast, e.last);
                end
            end
        end
        o_pending = want_points.size();
    end
endmodule

// ===== tb/extreme_point_update_2d_tb.sv =====
// Top of the extreme_point_update_2d testbench: clock, reset, commands and verdict.
// Depends on epu2d_pkg, the block itself and extreme_point_update_2d_check.
`timescale 1ns / 1ps

module extreme_point_update_2d_tb;
    import epu2d_pkg::*;

    localparam bit MODE_PLACE = 1'b0;
    localparam bit MODE_CLEAR = 1'b1;

    typedef struct {
        bit [15:0] x, y, l, d;
    } seen_point_t;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_idx = CFG_LEN;
    logic [15:0] i_cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    // tdata, low to high: item_x, item_y, item_len, item_dep
    logic [63:0] s_axis_tdata = 0;
    // tuser: mode
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1;
    // tdata, low to high: point_x, point_y, point_len, point_dep
    logic [63:0] m_axis_tdata;
    // tuser, low to high: point_valid, status[1:0]
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count, pending;
    int burst_left = 0;
    int cmds_sent = 0, lists_done = 0;
    seen_point_t list_building[$], last_list[$];

    extreme_point_update_2d dut (.*);

    extreme_point_update_2d_check checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver switches at random between its stall styles:
    // always ready, coin flip, or ready a quarter of the time.
    int ready_style = 0, ready_phase = 0;
    always @(negedge i_clk) begin
        ready_phase++;
        if (ready_phase % 200 == 0) ready_style = $urandom_range(0, 2);
        case (ready_style)
            0: m_axis_tready = 1;
            1: m_axis_tready = 1'($urandom_range(0, 1));
            default: m_axis_tready = (ready_phase % 4 == 0);
        endcase
    end

    // The stimulus keeps its own copy of the latest list so that well-formed
    // placements can land on a real extreme point.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (m_axis_tuser[0])
                list_building.push_back('{m_axis_tdata[15:0], m_axis_tdata[31:16],
                                          m_axis_tdata[47:32], m_axis_tdata[63:48]});
            if (m_axis_tlast) begin
                last_list = list_building;
                list_building.delete();
                lists_done++;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is
    // taken with tvalid still high, so back-to-back items need no toggle.
    task automatic send_cmd(bit mode, bit [15:0] x, bit [15:0] y, bit [15:0] l, bit [15:0] d);
        if (burst_left == 0) begin
            s_axis_tvalid = 0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        s_axis_tvalid = 1;
        s_axis_tuser = mode;
        s_axis_tdata = {d, l, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        cmds_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 0;
        burst_left = 0;
        while (pending != 0 || lists_done != cmds_sent) @(negedge i_clk);
    endtask

    // Registers change only once every list has been read out.
    task automatic write_reg(logic idx, bit [15:0] value);
        wait_idle();
        repeat (5) @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic place_on_point();
        seen_point_t p;
        int cap;
        wait_idle();
        if (last_list.size() == 0) begin
            send_cmd(MODE_PLACE, 16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                     16'($urandom_range(1, 50)), 16'($urandom_range(1, 50)));
        end else begin
            p = last_list[$urandom_range(0, last_list.size() - 1)];
            cap = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 300);
            send_cmd(MODE_PLACE, p.x, p.y,
                     16'($urandom_range(1, (p.l < cap) ? p.l : cap)),
                     16'($urandom_range(1, (p.d < cap) ? p.d : cap)));
        end
    endtask

    task automatic place_noise();
        if ($urandom_range(0, 1))
            send_cmd(MODE_PLACE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
            send_cmd(MODE_PLACE, 16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)),
                     16'($urandom_range(0, 120)), 16'($urandom_range(0, 120)));
    endtask

    initial begin
        bit [15:0] v;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: a bin-filling item leaves an empty list, extreme corners and sizes,
        // zero-size items, equal positions and a plain staircase.
        send_cmd(MODE_PLACE, 0, 0, 16'hFFFF, 16'hFFFF);
        send_cmd(MODE_PLACE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(MODE_CLEAR, 0, 0, 0, 0);
        send_cmd(MODE_PLACE, 0, 0, 10, 20);
        send_cmd(MODE_PLACE, 10, 0, 5, 5);
        send_cmd(MODE_PLACE, 0, 20, 0, 0);
        send_cmd(MODE_PLACE, 15, 0, 16'hFFF0, 3);
        send_cmd(MODE_PLACE, 16'hFFFF, 0, 1, 1);
        send_cmd(MODE_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Smallest bin, then a zero-size bin, then a size change without a clear.
        write_reg(CFG_LEN, 1);
        write_reg(CFG_DEP, 1);
        send_cmd(MODE_CLEAR, 0, 0, 0, 0);
        send_cmd(MODE_PLACE, 0, 0, 1, 1);
        send_cmd(MODE_CLEAR, 0, 0, 0, 0);
        write_reg(CFG_LEN, 0);
        send_cmd(MODE_CLEAR, 0, 0, 0, 0);
        send_cmd(MODE_PLACE, 0, 0, 1, 1);
        write_reg(CFG_LEN, 500);
        write_reg(CFG_DEP, 400);
        send_cmd(MODE_CLEAR, 0, 0, 0, 0);
        send_cmd(MODE_PLACE, 0, 0, 100, 100);
        write_reg(CFG_LEN, 300);
        send_cmd(MODE_PLACE, 100, 0, 50, 50);
        write_reg(CFG_LEN, 16'hFFFF);
        write_reg(CFG_DEP, 16'hFFFF);

        // A descending staircase adds one point per step until the list overflows.
        send_cmd(MODE_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 40; i++)
            send_cmd(MODE_PLACE, 16'(10 * i), 0, 10, 16'(1000 - 10 * i));

        // Small items until the rectangle store is full and further items are ignored.
        send_cmd(MODE_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 68; i++) place_noise();
        send_cmd(MODE_CLEAR, 0, 0, 0, 0);

        // Random part: mostly placements on real extreme points, some clears, the rest noise.
        for (int i = 0; i < 90; i++) begin
            if (i % 60 == 59) begin
                v = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(1, 2000));
                write_reg(CFG_LEN, v);
                v = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(1, 2000));
                write_reg(CFG_DEP, v);
                if ($urandom_range(0, 1))
                    send_cmd(MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
            end
            case ($urandom_range(0, 99)) inside
                [0:2]:   send_cmd(MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
                [3:69]:  place_on_point();
                default: place_noise();
            endcase
        end

        wait_idle();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0)
            $display("extreme_point_update_2d_tb OK");
        else
            $display("extreme_point_update_2d_tb NOT OK");
        $finish;
    end

    initial begin
        #200ms;
        $display("extreme_point_update_2d_tb NOT OK");
        $finish;
    end
endmodule
